[hw/rtl/assert_macros.svh]
// assertion macros used by bpfp_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define BPFP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bpfp assertion failed");

// antecedent implies consequent in the same cycle
`define BPFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpfp implication failed");

`endif

[hw/rtl/bpfp_pkg.sv]
// types, codes and constants for the battery monitor poll and frame parser
// no dependencies
`timescale 1ns / 1ps

package bpfp_pkg;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned INTERVAL_W = 18;
    localparam int unsigned LIMIT_W = 19;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [INTERVAL_W-1:0] MS_PER_SECOND = 18'd1000;
    localparam logic [LIMIT_W-1:0] TIMEOUT_EXTRA_MS = 19'd250;

    localparam logic [7:0] START_MARKER_RST = 8'd221;
    localparam logic [7:0] END_MARKER_RST = 8'd119;
    localparam logic [7:0] POLL_SECONDS_RST = 8'd5;

    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_BUSY = 3'd1;
    localparam logic [2:0] ST_WAIT_POLL = 3'd2;
    localparam logic [2:0] ST_TX_UNAVAIL = 3'd3;
    localparam logic [2:0] ST_REQ_SENT = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_FRAME_DONE = 3'd6;
    localparam logic [2:0] ST_BAD_END = 3'd7;

    localparam logic [1:0] CMD_HW_VERSION = 2'd0;
    localparam logic [1:0] CMD_BASIC_INFO = 2'd1;
    localparam logic [1:0] CMD_CELL_VOLTS = 2'd2;
    localparam logic [1:0] CMD_NONE_SENT = 2'd3;

    localparam logic ACT_BYTE = 1'b0;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_POLL_SECONDS = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAIT      = 4'd1,
        PH_START     = 4'd2,
        PH_STATUS    = 4'd3,
        PH_CMD       = 4'd4,
        PH_DATA      = 4'd5,
        PH_DATA_DONE = 4'd6,
        PH_CK1       = 4'd7,
        PH_CK2       = 4'd8
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       byte_kept;
        logic       frame_end;
        logic       frame_drop;
    } t_out;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] poll_seconds;
    } t_cfg;

    function automatic logic [1:0] next_command(input logic [1:0] prev);
        logic [1:0] cmd;
        case (prev)
            CMD_NONE_SENT:  cmd = CMD_HW_VERSION;
            CMD_BASIC_INFO: cmd = CMD_CELL_VOLTS;
            default:        cmd = CMD_BASIC_INFO;
        endcase
        return cmd;
    endfunction

endpackage

[hw/rtl/bms_poll_and_frame_parser.sv]
// channel   dir  payload   handshake
// in        in   t_in      i_in_valid / o_in_stall
// out       out  t_out     o_out_valid / i_out_stall
// cfg       in   apb       psel penable pwrite pready
// one request per cycle sustained while i_out_stall is low; path: input register, result register
// the combinational result path through bpfp_core sets the rate
// synchronous active-low reset clears both valid flags and the parser state
// a stalled result holds the result register; the input register then holds one more request
// top level: input register, core logic, result register; depends on bpfp_pkg,
// bpfp_regs and bpfp_core
`timescale 1ns / 1ps

module bms_poll_and_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bpfp_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bpfp_pkg::t_out                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfp_pkg::PADDR_W-1:0] paddr,
    input  logic [bpfp_pkg::PDATA_W-1:0] pwdata,
    output logic [bpfp_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import bpfp_pkg::*;

    t_cfg cfg;
    t_in r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    t_out res;
    logic fire;
    logic in_acc;

    bpfp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign fire = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~fire;
    assign in_acc = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc | (r_in_valid & ~fire);
            r_out_valid <= fire | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_in <= i_in_data;
        if (fire) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

[hw/rtl/bpfp_regs.sv]
// apb configuration registers: markers and poll interval
// depends on bpfp_pkg
`timescale 1ns / 1ps

module bpfp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfp_pkg::PADDR_W-1:0] paddr,
    input  logic [bpfp_pkg::PDATA_W-1:0] pwdata,
    output logic [bpfp_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output bpfp_pkg::t_cfg                o_cfg
);
    import bpfp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite;
    assign idx = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        prdata = '0;
        unique case (idx)
            REG_START_MARKER: begin
                prdata = {24'd0, r_cfg.start_marker};
                if (wr_en) n_cfg.start_marker = pwdata[7:0];
            end
            REG_END_MARKER: begin
                prdata = {24'd0, r_cfg.end_marker};
                if (wr_en) n_cfg.end_marker = pwdata[7:0];
            end
            REG_POLL_SECONDS: begin
                prdata = {24'd0, r_cfg.poll_seconds};
                if (wr_en) n_cfg.poll_seconds = pwdata[7:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker <= END_MARKER_RST;
            r_cfg.poll_seconds <= POLL_SECONDS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/bpfp_core.sv]
// parser and poll state with the per-item result logic
// depends on bpfp_pkg
`timescale 1ns / 1ps

module bpfp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  bpfp_pkg::t_in  i_item,
    input  bpfp_pkg::t_cfg i_cfg,
    output bpfp_pkg::t_out o_res
);
    import bpfp_pkg::*;

    t_phase r_phase, n_phase;
    logic [7:0] r_left, n_left;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [1:0] r_prev, n_prev;

    logic [INTERVAL_W-1:0] interval;
    logic [LIMIT_W-1:0] limit;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [7:0] left_dec;
    t_out res;

    assign interval = INTERVAL_W'(i_cfg.poll_seconds) * MS_PER_SECOND;
    assign limit = {interval, 1'b0} + TIMEOUT_EXTRA_MS;
    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_left = r_left;
        n_elapsed = r_elapsed;
        n_prev = r_prev;
        res = '0;
        if (i_item.action == ACT_BYTE) begin
            res.data_byte = i_item.rx_byte;
            unique case (r_phase) inside
                PH_IDLE, PH_WAIT: begin
                    if (i_item.rx_byte == i_cfg.start_marker) begin
                        res.byte_kept = 1'b1;
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_START: begin
                    res.byte_kept = 1'b1;
                    n_phase = PH_STATUS;
                end
                PH_STATUS: begin
                    res.byte_kept = 1'b1;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    res.byte_kept = 1'b1;
                    n_left = i_item.rx_byte;
                    n_phase = (i_item.rx_byte == 8'd0) ? PH_DATA_DONE : PH_DATA;
                end
                PH_DATA: begin
                    res.byte_kept = 1'b1;
                    n_left = left_dec;
                    n_phase = (left_dec == 8'd0) ? PH_DATA_DONE : PH_DATA;
                end
                PH_DATA_DONE: begin
                    res.byte_kept = 1'b1;
                    n_phase = PH_CK1;
                end
                PH_CK1: begin
                    res.byte_kept = 1'b1;
                    n_phase = PH_CK2;
                end
                PH_CK2: begin
                    if (i_item.rx_byte == i_cfg.end_marker) begin
                        res.byte_kept = 1'b1;
                        res.frame_end = 1'b1;
                        res.status = ST_FRAME_DONE;
                    end else begin
                        res.frame_drop = 1'b1;
                        res.status = ST_BAD_END;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    res.frame_drop = 1'b1;
                    n_phase = PH_IDLE;
                end
            endcase
        end else begin
            n_elapsed = elapsed_inc;
            if (r_phase != PH_IDLE) begin
                res.status = ST_BUSY;
            end else if (elapsed_inc < ELAPSED_W'(interval)) begin
                res.status = ST_WAIT_POLL;
            end else if (!i_item.tx_ready) begin
                res.status = ST_TX_UNAVAIL;
            end else begin
                res.command = next_command(r_prev);
                n_prev = res.command;
                n_elapsed = '0;
                n_phase = PH_WAIT;
                res.status = ST_REQ_SENT;
            end
            if (n_elapsed > ELAPSED_W'(limit)) begin
                if (4'(n_phase) >= 4'(PH_START)) res.frame_drop = 1'b1;
                n_phase = PH_IDLE;
                res.status = ST_TIMEOUT;
                res.command = CMD_HW_VERSION;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left <= '0;
            r_elapsed <= '0;
            r_prev <= CMD_NONE_SENT;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_left <= n_left;
            r_elapsed <= n_elapsed;
            r_prev <= n_prev;
        end
    end

    assign o_res = res;

endmodule

[hw/rtl/bpfp_checker.sv]
// port-level checks on results of the poll and frame parser, with bind
// depends on bpfp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpfp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bpfp_pkg::t_out o_out_data
);
    import bpfp_pkg::*;

    `BPFP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
    `BPFP_ASSERT_IMP(a_cmd_only_sent, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_REQ_SENT, o_out_data.command == CMD_HW_VERSION)
    `BPFP_ASSERT_IMP(a_end_is_done, i_clk, i_rst_n, o_out_valid && o_out_data.frame_end, o_out_data.status == ST_FRAME_DONE && o_out_data.byte_kept && !o_out_data.frame_drop)
    `BPFP_ASSERT_IMP(a_tick_no_byte, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_BUSY || o_out_data.status == ST_WAIT_POLL || o_out_data.status == ST_TX_UNAVAIL || o_out_data.status == ST_REQ_SENT || o_out_data.status == ST_TIMEOUT), o_out_data.data_byte == 8'd0 && !o_out_data.byte_kept && !o_out_data.frame_end)

endmodule

bind bms_poll_and_frame_parser bpfp_checker u_bpfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[test/poll_frame_checker.sv]
// checker for the battery monitor poll and frame parser: watches the request, result and
// register ports, predicts every result and compares it field by field
// depends on bpfp_pkg
`timescale 1ns / 1ps

module poll_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  bpfp_pkg::t_in                 i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  bpfp_pkg::t_out                i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bpfp_pkg::PADDR_W-1:0] i_paddr,
    input  logic [bpfp_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [bpfp_pkg::PDATA_W-1:0] i_prdata,
    input  logic                          i_pready,
    output int                            o_mismatches,
    output int                            o_pending
);
    import bpfp_pkg::*;

    t_cfg                 cfg;
    t_phase               phase;
    logic [7:0]           data_left;
    logic [ELAPSED_W-1:0] elapsed;
    logic [1:0]           last_cmd;
    t_out                 expected_reports[$];
    int                   mismatches;

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic t_out next_report(input t_in req);
        t_out        rep;
        int unsigned interval;
        int unsigned limit;
        rep = '0;
        if (req.action == ACT_BYTE) begin
            rep.data_byte = req.rx_byte;
            case (phase)
                PH_IDLE, PH_WAIT: begin
                    if (req.rx_byte == cfg.start_marker) begin
                        rep.byte_kept = 1'b1;
                        phase = PH_START;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_START: begin
                    rep.byte_kept = 1'b1;
                    phase = PH_STATUS;
                end
                PH_STATUS: begin
                    rep.byte_kept = 1'b1;
                    phase = PH_CMD;
                end
                PH_CMD: begin
                    rep.byte_kept = 1'b1;
                    data_left = req.rx_byte;
                    if (req.rx_byte == 8'd0) phase = PH_DATA_DONE;
                    else phase = PH_DATA;
                end
                PH_DATA: begin
                    rep.byte_kept = 1'b1;
                    data_left = data_left - 8'd1;
                    if (data_left == 8'd0) phase = PH_DATA_DONE;
                end
                PH_DATA_DONE: begin
                    rep.byte_kept = 1'b1;
                    phase = PH_CK1;
                end
                PH_CK1: begin
                    rep.byte_kept = 1'b1;
                    phase = PH_CK2;
                end
                PH_CK2: begin
                    if (req.rx_byte == cfg.end_marker) begin
                        rep.byte_kept = 1'b1;
                        rep.frame_end = 1'b1;
                        rep.status = ST_FRAME_DONE;
                    end else begin
                        rep.frame_drop = 1'b1;
                        rep.status = ST_BAD_END;
                    end
                    phase = PH_IDLE;
                end
                default: begin
                    rep.frame_drop = 1'b1;
                    phase = PH_IDLE;
                end
            endcase
        end else begin
            interval = int'(cfg.poll_seconds) * int'(MS_PER_SECOND);
            limit = 2 * interval + int'(TIMEOUT_EXTRA_MS);
            if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
            if (phase != PH_IDLE) begin
                rep.status = ST_BUSY;
            end else if (int'(elapsed) < interval) begin
                rep.status = ST_WAIT_POLL;
            end else if (!req.tx_ready) begin
                rep.status = ST_TX_UNAVAIL;
            end else begin
                case (last_cmd)
                    CMD_NONE_SENT:  rep.command = CMD_HW_VERSION;
                    CMD_BASIC_INFO: rep.command = CMD_CELL_VOLTS;
                    default:        rep.command = CMD_BASIC_INFO;
                endcase
                last_cmd = rep.command;
                elapsed = '0;
                phase = PH_WAIT;
                rep.status = ST_REQ_SENT;
            end
            // timeout overrides whatever the poll decision reported
            if (int'(elapsed) > limit) begin
                if (phase >= PH_START) rep.frame_drop = 1'b1;
                phase = PH_IDLE;
                rep.status = ST_TIMEOUT;
                rep.command = CMD_HW_VERSION;
            end
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out        want;
        logic [7:0]  reg_val;
        if (!i_rst_n) begin
            cfg.start_marker = START_MARKER_RST;
            cfg.end_marker = END_MARKER_RST;
            cfg.poll_seconds = POLL_SECONDS_RST;
            phase = PH_IDLE;
            data_left = '0;
            elapsed = '0;
            last_cmd = CMD_NONE_SENT;
            expected_reports.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, i_out_data);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("status", want.status, i_out_data.status);
                    compare_field("command", want.command, i_out_data.command);
                    compare_field("data_byte", want.data_byte, i_out_data.data_byte);
                    compare_field("byte_kept", want.byte_kept, i_out_data.byte_kept);
                    compare_field("frame_end", want.frame_end, i_out_data.frame_end);
                    compare_field("frame_drop", want.frame_drop, i_out_data.frame_drop);
                end
            end
            if (i_psel && i_penable && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_START_MARKER: reg_val = cfg.start_marker;
                    REG_END_MARKER:   reg_val = cfg.end_marker;
                    default:          reg_val = cfg.poll_seconds;
                endcase
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_START_MARKER: cfg.start_marker = i_pwdata[7:0];
                        REG_END_MARKER:   cfg.end_marker = i_pwdata[7:0];
                        REG_POLL_SECONDS: cfg.poll_seconds = i_pwdata[7:0];
                        default: ;
                    endcase
                end else begin
                    compare_field("register read", reg_val, i_prdata);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_reports = {expected_reports, next_report(i_in_data)};
            end
        end
        o_pending <= expected_reports.size();
        o_mismatches <= mismatches;
    end

endmodule

[test/testbench.sv]
// top of the poll and frame parser test: clock, reset, request and register stimulus,
// result stalls and the verdict; prediction lives in poll_frame_checker
// depends on bpfp_pkg, poll_frame_checker and bms_poll_and_frame_parser
`timescale 1ns / 1ps

module testbench;
    import bpfp_pkg::*;

    localparam int   CYCLE_LIMIT = 500000;
    localparam logic ACT_TICK = ~ACT_BYTE;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_in                in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out               out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 cycles = 0;
    int                 items_sent = 0;
    int                 in_gap_max = 6;
    int                 out_stall_max = 6;
    logic [7:0]         start_mk = START_MARKER_RST;
    logic [7:0]         end_mk = END_MARKER_RST;

    always #10 clk = ~clk;

    bms_poll_and_frame_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    poll_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall before taking each result
    initial begin : result_sink
        int n;
        forever begin
            n = $urandom_range(out_stall_max, 0);
            if (n != 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send(input t_in req);
        int gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in req;
        req.action = ACT_BYTE;
        req.rx_byte = b;
        req.tx_ready = 1'($urandom_range(1, 0));
        send(req);
    endtask

    task automatic send_tick(input logic ready);
        t_in req;
        req.action = ACT_TICK;
        req.rx_byte = 8'($urandom);
        req.tx_ready = ready;
        send(req);
    endtask

    task automatic apb_access(input logic wr, input t_reg_idx idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic read_back;
        apb_access(1'b0, REG_START_MARKER, 8'd0);
        apb_access(1'b0, REG_END_MARKER, 8'd0);
        apb_access(1'b0, REG_POLL_SECONDS, 8'd0);
    endtask

    task automatic configure(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p);
        drain();
        apb_access(1'b1, REG_START_MARKER, s);
        apb_access(1'b1, REG_END_MARKER, e);
        apb_access(1'b1, REG_POLL_SECONDS, p);
        start_mk = s;
        end_mk = e;
        read_back();
    endtask

    // cut < 0 sends the whole frame, otherwise only the first cut bytes
    task automatic send_frame(input bit good_end, input int cut);
        logic [7:0] frame[$];
        int         len;
        len = ($urandom_range(99, 0) == 0) ? $urandom_range(255, 9) : $urandom_range(6, 0);
        frame = {frame, start_mk};
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'(len)};
        repeat (len) frame = {frame, 8'($urandom)};
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'($urandom)};
        frame = {frame, good_end ? end_mk : end_mk + 8'($urandom_range(255, 1))};
        foreach (frame[i]) begin
            if (cut >= 0 && i >= cut) break;
            if ($urandom_range(9, 0) == 0) send_tick(1'($urandom_range(1, 0)));
            send_byte(frame[i]);
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        int pick;
        stop = items_sent + count;
        while (items_sent < stop) begin
            in_gap_max = ($urandom_range(4, 0) == 0) ? 0 : 6;
            out_stall_max = ($urandom_range(4, 0) == 0) ? 0 : 6;
            pick = $urandom_range(19, 0);
            if (pick < 11) begin
                send_frame(1'b1, -1);
            end else if (pick < 13) begin
                send_frame(1'b0, -1);
            end else if (pick < 14) begin
                send_frame(1'b1, $urandom_range(8, 1));
            end else if (pick < 17) begin
                repeat ($urandom_range(8, 1)) send_tick($urandom_range(3, 0) != 0);
            end else if (pick < 19) begin
                repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(40, 10)) send_tick(1'($urandom_range(1, 0)));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_back();

        // reset settings: stray bytes, waiting ticks, a complete and a broken frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_MARKER_RST);
        send_tick(1'b1);
        send_tick(1'b0);
        send_byte(START_MARKER_RST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_tick(1'b1);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(END_MARKER_RST);
        send_byte(START_MARKER_RST);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h02);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);

        // zero poll interval: request rotation, timeout of a partial frame and of an idle link
        configure(8'h00, 8'hFF, 8'h00);
        send_byte(8'h5A);
        send_tick(1'b0);
        send_tick(1'b1);
        send_byte(8'h33);
        send_tick(1'b1);
        send_byte(8'h00);
        send_byte(8'h01);
        repeat (252) send_tick(1'b1);
        send_byte(8'h44);
        repeat (253) send_tick(1'b0);
        send_tick(1'b1);
        run_random(100);

        configure(8'hFF, 8'h00, 8'hFF);
        run_random(100);

        configure(8'($urandom), 8'($urandom), 8'h01);
        run_random(100);

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bpfp_pkg.sv
hw/rtl/bpfp_regs.sv
hw/rtl/bpfp_core.sv
hw/rtl/bms_poll_and_frame_parser.sv
hw/rtl/bpfp_checker.sv
test/poll_frame_checker.sv
test/testbench.sv
